// ----- hdl/ritp_pkg.sv -----
package ritp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // stack entry codes, ordered by precedence above OPEN
  typedef enum logic [1:0] {
    OP_OPEN = 2'd0,
    OP_BAR  = 2'd1,
    OP_DOT  = 2'd2,
    OP_STAR = 2'd3
  } op_code_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_UNCLOSED  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_LETTER = 3'd1,
    CLS_OPEN   = 3'd2,
    CLS_CLOSE  = 3'd3,
    CLS_BAR    = 3'd4,
    CLS_DOT    = 3'd5,
    CLS_STAR   = 3'd6,
    CLS_END    = 3'd7
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
    err_e       err;
  } res_t;

  function automatic logic [7:0] code_char(op_code_e c);
    logic [7:0] r;
    case (c)
      OP_OPEN: r = CH_OPEN;
      OP_BAR:  r = CH_BAR;
      OP_DOT:  r = CH_DOT;
      OP_STAR: r = CH_STAR;
      default: r = CH_OPEN;
    endcase
    return r;
  endfunction

  function automatic op_code_e cls_code(cls_e c);
    op_code_e r;
    case (c)
      CLS_BAR:  r = OP_BAR;
      CLS_DOT:  r = OP_DOT;
      CLS_STAR: r = OP_STAR;
      default:  r = OP_OPEN;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/ritp_ram.sv -----
module ritp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ritp_front.sv -----
module ritp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_char_i,
  input  logic             end_of_expr_i,
  output logic             cmd_valid_o,
  output ritp_pkg::cmd_t   cmd_o,
  input  logic             cmd_ready_i
);

  ritp_pkg::cmd_t                    q_mem_q [ritp_pkg::QUEUE_DEPTH];
  logic [ritp_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ritp_pkg::QCNT_W-1:0]       fill_q, fill_d;
  ritp_pkg::cls_e                    cls;
  logic                              wr_en, rd_en;

  // classify the incoming byte
  always_comb begin
    if (end_of_expr_i) begin
      cls = ritp_pkg::CLS_END;
    end else if (in_char_i inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      cls = ritp_pkg::CLS_LETTER;
    end else begin
      case (in_char_i)
        ritp_pkg::CH_OPEN:  cls = ritp_pkg::CLS_OPEN;
        ritp_pkg::CH_CLOSE: cls = ritp_pkg::CLS_CLOSE;
        ritp_pkg::CH_BAR:   cls = ritp_pkg::CLS_BAR;
        ritp_pkg::CH_DOT:   cls = ritp_pkg::CLS_DOT;
        ritp_pkg::CH_STAR:  cls = ritp_pkg::CLS_STAR;
        default:            cls = ritp_pkg::CLS_NONE;
      endcase
    end
  end

  assign full        = (fill_q == ritp_pkg::QCNT_W'(ritp_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // drop bytes that carry no meaning
  assign wr_en = push && !full && (cls != ritp_pkg::CLS_NONE);
  assign rd_en = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == ritp_pkg::QPTR_W'(ritp_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + ritp_pkg::QPTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == ritp_pkg::QPTR_W'(ritp_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + ritp_pkg::QPTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      fill_d = fill_q + ritp_pkg::QCNT_W'(1);
    end else if (!wr_en && rd_en) begin
      fill_d = fill_q - ritp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem_q[wr_ptr_q] <= '{cls: cls, ch: in_char_i};
    end
  end

endmodule

// ----- hdl/ritp_back.sv -----
module ritp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  ritp_pkg::cmd_t   cmd_i,
  output logic             cmd_ready_o,
  output logic             empty,
  input  logic             pop,
  output ritp_pkg::res_t   res_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PUSH  = 5'b00010,
    S_CHECK = 5'b00100,
    S_EVAL  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  ritp_pkg::cmd_t                cmd_q, cmd_d;
  logic [ritp_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          open_q, open_d;
  ritp_pkg::res_t                pend_q, pend_d, out_q, out_d, emit_res;
  logic                          pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;
  logic                          emit, finish_last, can_emit, out_free, we;
  logic [1:0]                    rdata;
  ritp_pkg::op_code_e            top_code;
  logic [ritp_pkg::IDX_W-1:0]    raddr, waddr;

  // the stack RAM is always read at the top entry; its data shows in the next cycle
  assign raddr = ritp_pkg::IDX_W'(cnt_q - ritp_pkg::CNT_W'(1));
  assign waddr = ritp_pkg::IDX_W'(cnt_q);

  ritp_ram #(
    .WIDTH (2),
    .DEPTH (ritp_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (ritp_pkg::cls_code(cmd_q.cls)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign top_code = ritp_pkg::op_code_e'(rdata);
  assign out_free = !out_vld_q || pop;
  assign can_emit = !pend_vld_q || out_free;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    open_d      = open_q;
    emit        = 1'b0;
    emit_res    = '{ch: 8'h00, last: 1'b0, done: 1'b0, err: ritp_pkg::ERR_NONE};
    finish_last = 1'b0;
    we          = 1'b0;
    cmd_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d  = cmd_i;
          open_d = 1'b0;
          case (cmd_i.cls)
            ritp_pkg::CLS_LETTER: begin
              emit        = 1'b1;
              emit_res.ch = cmd_i.ch;
              state_d     = S_FLUSH;
            end
            ritp_pkg::CLS_OPEN, ritp_pkg::CLS_STAR: state_d = S_PUSH;
            default:                                state_d = S_CHECK;
          endcase
        end
      end
      S_PUSH: begin
        if (cnt_q == ritp_pkg::CNT_W'(ritp_pkg::STACK_DEPTH)) begin
          if (can_emit) begin
            emit         = 1'b1;
            emit_res.err = ritp_pkg::ERR_OVERFLOW;
            state_d      = S_FLUSH;
          end
        end else begin
          we      = 1'b1;
          cnt_d   = cnt_q + ritp_pkg::CNT_W'(1);
          state_d = S_FLUSH;
        end
      end
      S_CHECK: begin
        if (cnt_q == '0) begin
          case (cmd_q.cls)
            ritp_pkg::CLS_CLOSE: begin
              if (can_emit) begin
                emit         = 1'b1;
                emit_res.err = ritp_pkg::ERR_UNMATCHED;
                state_d      = S_FLUSH;
              end
            end
            ritp_pkg::CLS_END: begin
              if (can_emit) begin
                emit          = 1'b1;
                emit_res.done = 1'b1;
                emit_res.err  = open_q ? ritp_pkg::ERR_UNCLOSED : ritp_pkg::ERR_NONE;
                state_d       = S_FLUSH;
              end
            end
            default: state_d = S_PUSH;
          endcase
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (cmd_q.cls)
          ritp_pkg::CLS_CLOSE: begin
            if (top_code == ritp_pkg::OP_OPEN) begin
              cnt_d   = cnt_q - ritp_pkg::CNT_W'(1);
              state_d = S_FLUSH;
            end else if (can_emit) begin
              emit        = 1'b1;
              emit_res.ch = ritp_pkg::code_char(top_code);
              cnt_d       = cnt_q - ritp_pkg::CNT_W'(1);
              state_d     = S_CHECK;
            end
          end
          ritp_pkg::CLS_END: begin
            if (top_code == ritp_pkg::OP_OPEN) begin
              open_d  = 1'b1;
              cnt_d   = cnt_q - ritp_pkg::CNT_W'(1);
              state_d = S_CHECK;
            end else if (can_emit) begin
              emit        = 1'b1;
              emit_res.ch = ritp_pkg::code_char(top_code);
              cnt_d       = cnt_q - ritp_pkg::CNT_W'(1);
              state_d     = S_CHECK;
            end
          end
          default: begin
            // bar or dot: stop at an open or at a lower precedence
            if (top_code == ritp_pkg::OP_OPEN ||
                top_code < ritp_pkg::cls_code(cmd_q.cls)) begin
              state_d = S_PUSH;
            end else if (can_emit) begin
              emit        = 1'b1;
              emit_res.ch = ritp_pkg::code_char(top_code);
              cnt_d       = cnt_q - ritp_pkg::CNT_W'(1);
              state_d     = S_CHECK;
            end
          end
        endcase
      end
      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          finish_last = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold one result back until it is known whether it is the last one
  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !pop;
    if (emit) begin
      if (pend_vld_q) begin
        out_d     = pend_q;
        out_vld_d = 1'b1;
      end
      pend_d     = emit_res;
      pend_vld_d = 1'b1;
    end
    if (finish_last) begin
      out_d      = pend_q;
      out_d.last = 1'b1;
      out_vld_d  = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      open_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      open_q     <= open_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign empty = !out_vld_q;
  assign res_o = out_q;

endmodule

// ----- hdl/regex_infix_to_postfix_core.sv -----
// Channel   Handshake      Transfer when        Payload
// input     push / full    push && !full        in_char_i, end_of_expr_i
// result    empty / pop    pop && !empty        out_char_o, last_o, done_res_o, error_code_o
//
// A letter passes through IDLE and FLUSH, a push of '(' or '*' through IDLE, PUSH
// and FLUSH, and every stack entry that ')', '|', '.' or an end item inspects adds a
// CHECK state to address the stack RAM at its top entry and an EVAL state to act on the registered read data.
// A two-entry command queue lets new characters in while the back end works.
// Reset (rst_ni low) empties the command queue, the stack and the result
// register at once; stack contents are never cleared, only the count.
// A stalled result port holds the back end only when it has a result to move.
module regex_infix_to_postfix_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       end_of_expr_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic       done_res_o,
  output logic [1:0] error_code_o
);

  // classified commands from the front end to the stack sequencer
  logic            cmd_valid, cmd_ready;
  ritp_pkg::cmd_t  cmd;
  ritp_pkg::res_t  res;

  // front end: classify each character, drop the meaningless ones, queue
  ritp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_char_i     (in_char_i),
    .end_of_expr_i (end_of_expr_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  // back end: operator stack, pop loops and the result register
  ritp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign out_char_o   = res.ch;
  assign last_o       = res.last;
  assign done_res_o   = res.done;
  assign error_code_o = res.err;

endmodule

// ----- hdl/ritp_checker.sv -----
module ritp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [7:0] in_char_i,
  input logic       end_of_expr_i,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic       last_o,
  input logic       done_res_o,
  input logic [1:0] error_code_o
);

  // a terminator always closes its burst and carries no character
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> (last_o && out_char_o == 8'h00))
    else $error("terminator not last or carries a character");

  // an unclosed-open code only appears on a terminator
  a_unclosed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_code_o == ritp_pkg::ERR_UNCLOSED) |-> done_res_o)
    else $error("unclosed-open code without terminator");

  // stack errors end the burst, carry no character and are no terminator
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (error_code_o == ritp_pkg::ERR_UNMATCHED ||
                error_code_o == ritp_pkg::ERR_OVERFLOW))
      |-> (last_o && !done_res_o && out_char_o == 8'h00))
    else $error("malformed error result");

  // a waiting result holds until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(last_o)))
    else $error("waiting result changed");

endmodule

bind regex_infix_to_postfix_core ritp_checker u_ritp_checker (.*);

// ----- tb/tb_regex_infix_to_postfix_core.sv -----
`timescale 1ns / 100ps

module tb_regex_infix_to_postfix_core;

  // Worst case: ~400 transfers, each flushing up to 33 results,
  // with stalls on both sides. Take that several times over.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 250;

  // Postfix glyph for each stack code.
  localparam logic [7:0] GLYPH [4] = '{ritp_pkg::CH_OPEN, ritp_pkg::CH_BAR,
                                       ritp_pkg::CH_DOT, ritp_pkg::CH_STAR};

  typedef struct {
    logic [7:0] ch;
    logic       eoe;
    bit         drain;  // hold this item until every expected result is out
  } char_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_char = 8'h00;
  logic       end_of_expr = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       last;
  logic       done_res;
  logic [1:0] error_code;

  // Pending characters, filled up front and drained by the driver.
  char_item_t char_q[$];
  char_item_t nxt_item;
  int unsigned live_cnt = 0;

  // Predicted converter state and the postfix results still owed.
  ritp_pkg::op_code_e op_stk [ritp_pkg::STACK_DEPTH];
  int unsigned        stk_cnt = 0;
  ritp_pkg::res_t     postfix_q[$];
  ritp_pkg::res_t     want;

  int unsigned n_sent = 0;
  int unsigned n_bad = 0;
  int unsigned cycle_cnt = 0;
  logic        calm;

  regex_infix_to_postfix_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_char_i     (in_char),
    .end_of_expr_i (end_of_expr),
    .empty         (empty),
    .pop           (pop),
    .out_char_o    (out_char),
    .last_o        (last),
    .done_res_o    (done_res),
    .error_code_o  (error_code)
  );

  always #4 clk_i = ~clk_i;

  // Suppress idling on both sides for a long stretch in the middle of the run.
  assign calm = (n_sent >= 150) && (n_sent < 260);

  // ---------------------------------------------------------------------------
  // Converter prediction
  // ---------------------------------------------------------------------------
  function automatic bit is_letter(logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
  endfunction

  function automatic ritp_pkg::res_t mk_res(logic [7:0] ch, logic done,
                                            ritp_pkg::err_e err);
    ritp_pkg::res_t r;
    r.ch   = ch;
    r.last = 1'b0;
    r.done = done;
    r.err  = err;
    return r;
  endfunction

  // Push onto the predicted stack; drop the push and return 0 when full.
  function automatic bit stack_push(ritp_pkg::op_code_e code);
    if (stk_cnt >= ritp_pkg::STACK_DEPTH) return 1'b0;
    op_stk[stk_cnt] = code;
    stk_cnt++;
    return 1'b1;
  endfunction

  // Work out the postfix results one accepted character causes.
  task automatic convert_char(input logic [7:0] ch, input logic eoe);
    ritp_pkg::res_t     outs[$];
    ritp_pkg::op_code_e top;
    ritp_pkg::op_code_e code;
    logic               open_seen;
    logic               matched;
    open_seen = 1'b0;
    matched   = 1'b0;
    if (eoe) begin
      // Flush everything; discard stacked opens but remember them.
      while (stk_cnt > 0) begin
        stk_cnt--;
        top = op_stk[stk_cnt];
        if (top == ritp_pkg::OP_OPEN) open_seen = 1'b1;
        else outs.push_back(mk_res(GLYPH[top], 1'b0, ritp_pkg::ERR_NONE));
      end
      outs.push_back(mk_res(8'h00, 1'b1,
                            open_seen ? ritp_pkg::ERR_UNCLOSED : ritp_pkg::ERR_NONE));
    end else if (is_letter(ch)) begin
      outs.push_back(mk_res(ch, 1'b0, ritp_pkg::ERR_NONE));
    end else if (ch == ritp_pkg::CH_OPEN || ch == ritp_pkg::CH_STAR) begin
      code = (ch == ritp_pkg::CH_OPEN) ? ritp_pkg::OP_OPEN : ritp_pkg::OP_STAR;
      if (!stack_push(code))
        outs.push_back(mk_res(8'h00, 1'b0, ritp_pkg::ERR_OVERFLOW));
    end else if (ch == ritp_pkg::CH_CLOSE) begin
      // Emit down to the nearest open; running dry means an unmatched close.
      while (stk_cnt > 0 && !matched) begin
        stk_cnt--;
        top = op_stk[stk_cnt];
        if (top == ritp_pkg::OP_OPEN) matched = 1'b1;
        else outs.push_back(mk_res(GLYPH[top], 1'b0, ritp_pkg::ERR_NONE));
      end
      if (!matched) outs.push_back(mk_res(8'h00, 1'b0, ritp_pkg::ERR_UNMATCHED));
    end else if (ch == ritp_pkg::CH_BAR || ch == ritp_pkg::CH_DOT) begin
      code = (ch == ritp_pkg::CH_BAR) ? ritp_pkg::OP_BAR : ritp_pkg::OP_DOT;
      while (stk_cnt > 0 && op_stk[stk_cnt-1] != ritp_pkg::OP_OPEN &&
             op_stk[stk_cnt-1] >= code) begin
        stk_cnt--;
        outs.push_back(mk_res(GLYPH[op_stk[stk_cnt]], 1'b0, ritp_pkg::ERR_NONE));
      end
      if (!stack_push(code))
        outs.push_back(mk_res(8'h00, 1'b0, ritp_pkg::ERR_OVERFLOW));
    end
    // Anything else is ignored and owes nothing.
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) postfix_q.push_back(outs[i]);
  endtask

  task automatic note_mismatch(input string what);
    n_bad++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic void add(logic [7:0] ch, logic eoe, bit drain = 1'b0);
    char_item_t it;
    it.ch    = ch;
    it.eoe   = eoe;
    it.drain = drain;
    char_q.push_back(it);
    if (eoe || is_letter(ch) || ch == ritp_pkg::CH_OPEN || ch == ritp_pkg::CH_CLOSE ||
        ch == ritp_pkg::CH_STAR || ch == ritp_pkg::CH_DOT || ch == ritp_pkg::CH_BAR)
      live_cnt++;
  endfunction

  function automatic logic [7:0] rnd_letter();
    if ($urandom_range(1)) return 8'("A" + $urandom_range(25));
    return 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rnd_op();
    case ($urandom_range(4))
      0: return ritp_pkg::CH_OPEN;
      1: return ritp_pkg::CH_CLOSE;
      2: return ritp_pkg::CH_STAR;
      3: return ritp_pkg::CH_DOT;
      default: return ritp_pkg::CH_BAR;
    endcase
  endfunction

  // Well-formed regex: terms joined by '.' or '|', terms are letters or
  // parenthesized subexpressions, each optionally starred.
  function automatic void gen_expr(int lvl);
    int n_terms;
    n_terms = $urandom_range(1, 4);
    for (int i = 0; i < n_terms; i++) begin
      if (i > 0) add($urandom_range(1) ? ritp_pkg::CH_DOT : ritp_pkg::CH_BAR, 1'b0);
      if (lvl > 0 && $urandom_range(99) < 30) begin
        add(ritp_pkg::CH_OPEN, 1'b0);
        gen_expr(lvl - 1);
        add(ritp_pkg::CH_CLOSE, 1'b0);
      end else begin
        add(rnd_letter(), 1'b0);
      end
      while ($urandom_range(3) == 0) add(ritp_pkg::CH_STAR, 1'b0);
    end
  endfunction

  // Pile the stack up to and past its depth, then close it out.
  function automatic void gen_deep();
    int k;
    k = $urandom_range(28, 36);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(5))
        0, 1: add(ritp_pkg::CH_OPEN, 1'b0);
        2, 3: add(ritp_pkg::CH_STAR, 1'b0);
        4:    add($urandom_range(1) ? ritp_pkg::CH_DOT : ritp_pkg::CH_BAR, 1'b0);
        default: add(rnd_letter(), 1'b0);
      endcase
    end
    for (int i = $urandom_range(3); i > 0; i--) add(rnd_op(), 1'b0);
    add(8'($urandom_range(255)), 1'b1);
  endfunction

  initial begin
    int unsigned target;
    bit          mid_drain;

    // Directed: letter and byte extremes, ignored neighbors of the letter ranges.
    add("A", 1'b0);
    add("Z", 1'b0);
    add("a", 1'b0);
    add("z", 1'b0);
    add(8'h00, 1'b0);
    add(8'hFF, 1'b0);
    add("[", 1'b0);
    add("{", 1'b0);
    add(8'hFF, 1'b1);
    // Every operator: (a|b).c*
    add(ritp_pkg::CH_OPEN, 1'b0);
    add("a", 1'b0);
    add(ritp_pkg::CH_BAR, 1'b0);
    add("b", 1'b0);
    add(ritp_pkg::CH_CLOSE, 1'b0);
    add(ritp_pkg::CH_DOT, 1'b0);
    add("c", 1'b0);
    add(ritp_pkg::CH_STAR, 1'b0);
    add(8'h00, 1'b1);
    // Unmatched close after a stacked star.
    add(ritp_pkg::CH_STAR, 1'b0);
    add(ritp_pkg::CH_CLOSE, 1'b0);
    // Unclosed open left at the end.
    add(ritp_pkg::CH_OPEN, 1'b0);
    add("x", 1'b0);
    add(ritp_pkg::CH_DOT, 1'b0);
    add(8'h5A, 1'b1);

    // Overflow: fill with opens, then push '(' and '.' onto the full stack.
    for (int i = 0; i < ritp_pkg::STACK_DEPTH; i++) add(ritp_pkg::CH_OPEN, 1'b0, i == 0);
    add(ritp_pkg::CH_OPEN, 1'b0);
    add(ritp_pkg::CH_DOT, 1'b0);
    add(ritp_pkg::CH_CLOSE, 1'b0);
    add(ritp_pkg::CH_STAR, 1'b0);
    add(ritp_pkg::CH_BAR, 1'b0);
    add(8'h00, 1'b1);
    // Longest flush: a full stack of stars.
    for (int i = 0; i < ritp_pkg::STACK_DEPTH; i++) add(ritp_pkg::CH_STAR, 1'b0);
    add(8'hA5, 1'b1);

    // Random part: mostly well-formed expressions, some deep piles, some noise.
    target    = live_cnt + RANDOM_ITEMS;
    mid_drain = 1'b0;
    while (live_cnt < target) begin
      if (!mid_drain && live_cnt > target - RANDOM_ITEMS / 2) begin
        add(rnd_letter(), 1'b0, 1'b1);
        mid_drain = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:71]: begin
          gen_expr(3);
          add(8'($urandom_range(255)), 1'b1);
        end
        [72:79]: gen_deep();
        default: begin
          for (int i = $urandom_range(1, 4); i > 0; i--) begin
            case ($urandom_range(3))
              0: add(8'($urandom_range(255)), 1'b0);
              1: add(rnd_op(), 1'b0);
              2: add(8'($urandom_range(255)), 1'b1);
              default: add(ritp_pkg::CH_CLOSE, 1'b0);
            endcase
          end
        end
      endcase
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transfer in, every result out, then watch for strays.
    while (char_q.size() != 0 || push) @(posedge clk_i);
    while (postfix_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: predict on each input transfer, then present the next character.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        convert_char(in_char, end_of_expr);
        n_sent++;
      end
      if (push && full) begin
        // hold the offered character until it transfers
      end else if (char_q.size() != 0 &&
                   !(char_q[0].drain && postfix_q.size() != 0) &&
                   (calm || $urandom_range(99) >= 9)) begin
        nxt_item    = char_q.pop_front();
        push        <= 1'b1;
        in_char     <= nxt_item.ch;
        end_of_expr <= nxt_item.eoe;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (postfix_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result char=%02h last=%b done=%b err=%0d",
                                  out_char, last, done_res, error_code));
        end else begin
          want = postfix_q.pop_front();
          if (out_char !== want.ch)
            note_mismatch($sformatf("out_char %02h, want %02h", out_char, want.ch));
          if (last !== want.last)
            note_mismatch($sformatf("last %b, want %b", last, want.last));
          if (done_res !== want.done)
            note_mismatch($sformatf("done_res %b, want %b", done_res, want.done));
          if (error_code !== want.err)
            note_mismatch($sformatf("error_code %0d, want %0d", error_code, want.err));
        end
      end
      pop <= calm || ($urandom_range(99) >= 9);
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
